### sv/mrfc_pkg.sv
`default_nettype none

package mrfc_pkg;

   // Default for the saturation point of the received byte count.
   localparam int MAX_FRAME_BYTES_DEFAULT = 256;

   // Depth of the job queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Reset value of the own slave address register.
   localparam logic [7:0] DEVICE_ADDRESS_RESET = 8'd1;

   // CRC-16/MODBUS constants.
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // Bit set in the function code of an exception reply.
   localparam logic [7:0] EXC_FUNC_FLAG = 8'h80;

   // Frame length limits for the verdict.
   localparam int MIN_FRAME_BYTES = 4;
   localparam int MIN_PDU_FRAME_BYTES = 8;

   // Input command codes.
   localparam logic [1:0] CMD_RX_BYTE  = 2'd0;
   localparam logic [1:0] CMD_OUTCOME  = 2'd1;
   localparam logic [1:0] CMD_PDU_BYTE = 2'd2;

   // Result kinds.
   localparam logic KIND_VERDICT = 1'b0;
   localparam logic KIND_TX_BYTE = 1'b1;

   // Verdict codes.
   localparam logic [2:0] VERDICT_ACCEPTED      = 3'd0;
   localparam logic [2:0] VERDICT_TOO_SHORT     = 3'd1;
   localparam logic [2:0] VERDICT_CRC_BAD       = 3'd2;
   localparam logic [2:0] VERDICT_NOT_ADDRESSED = 3'd3;
   localparam logic [2:0] VERDICT_PDU_SHORT     = 3'd4;

   // Protocol phase of the front.
   typedef enum logic [1:0] {
      PH_RECEIVING,
      PH_AWAITING,
      PH_RESPONDING
   } phase_type;

   // Kind of job handed from the front to the back.
   typedef enum logic [1:0] {
      JK_VERDICT,
      JK_EXCEPTION,
      JK_PDU
   } job_kind_type;

   // Transmit step of the back.
   typedef enum logic [2:0] {
      ST_ADDR,
      ST_FUNC,
      ST_DATA,
      ST_CRC_LO,
      ST_CRC_HI
   } step_type;

   // One queued job.
   typedef struct packed {
      job_kind_type kind;
      logic [2:0]   verdict;
      logic [7:0]   func;
      logic         broadcast;
      logic [7:0]   data;
      logic         first;
      logic         last;
   } job_type;

   // Queue status seen by the front and the back.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // One byte step of CRC-16/MODBUS, bit-reflected.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

### sv/mrfc_if.sv
`default_nettype none

// Request channel: one beat carries a command, a byte and an end mark.
interface mrfc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [7:0] data_byte;
   logic       last;

   modport source (output valid, output cmd, output data_byte, output last, input ready);
   modport sink   (input valid, input cmd, input data_byte, input last, output ready);
endinterface

// Response channel: one beat is a receive verdict or a transmit byte.
interface mrfc_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [2:0] verdict;
   logic [7:0] function_code;
   logic       is_broadcast;
   logic [7:0] tx_byte;
   logic       tx_last;

   modport source (output valid, output kind, output verdict, output function_code,
                   output is_broadcast, output tx_byte, output tx_last, input ready);
   modport sink   (input valid, input kind, input verdict, input function_code,
                   input is_broadcast, input tx_byte, input tx_last, output ready);
endinterface

`default_nettype wire

### sv/mrfc_front.sv
`default_nettype none

module mrfc_front #(
   parameter int MAX_FRAME_BYTES = mrfc_pkg::MAX_FRAME_BYTES_DEFAULT
) (
   input  wire                        clock,
   input  wire                        reset,
   mrfc_req_if.sink                   req_chan,
   input  wire [7:0]                  device_address,
   input  wire mrfc_pkg::queue_status_type q_status,
   output logic                       q_push,
   output mrfc_pkg::job_type          q_job
);

   localparam int CountWidth = $clog2(MAX_FRAME_BYTES + 1);

   logic [15:0]          rx_crc_ff, rx_crc_in;
   logic [CountWidth-1:0] rx_count_ff, rx_count_in;
   logic [7:0]           frame_addr_ff, frame_addr_in;
   logic [7:0]           frame_func_ff, frame_func_in;
   mrfc_pkg::phase_type  phase_ff, phase_in;
   logic                 tx_started_ff, tx_started_in;
   logic                 broadcast_ff, broadcast_in;

   logic                 accept;
   logic [15:0]          crc_next;
   logic [CountWidth-1:0] count_next;
   logic [7:0]           addr_next;
   logic [7:0]           func_next;
   logic                 bc_next;

   // A new beat is taken whenever the queue has room.
   assign req_chan.ready = !q_status.full;
   assign accept         = req_chan.valid && req_chan.ready;

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rx_crc_ff     <= mrfc_pkg::CRC_INIT;
         rx_count_ff   <= '0;
         frame_addr_ff <= '0;
         frame_func_ff <= '0;
         phase_ff      <= mrfc_pkg::PH_RECEIVING;
         tx_started_ff <= 1'b0;
         broadcast_ff  <= 1'b0;
      end else begin
         rx_crc_ff     <= rx_crc_in;
         rx_count_ff   <= rx_count_in;
         frame_addr_ff <= frame_addr_in;
         frame_func_ff <= frame_func_in;
         phase_ff      <= phase_in;
         tx_started_ff <= tx_started_in;
         broadcast_ff  <= broadcast_in;
      end
   end

   // Values seen after the current received byte.
   always_comb begin
      crc_next   = mrfc_pkg::crc_byte(rx_crc_ff, req_chan.data_byte);
      count_next = (rx_count_ff < CountWidth'(MAX_FRAME_BYTES)) ?
                   rx_count_ff + CountWidth'(1) : rx_count_ff;
      addr_next  = (rx_count_ff == '0) ? req_chan.data_byte : frame_addr_ff;
      func_next  = (rx_count_ff == CountWidth'(1)) ? req_chan.data_byte : frame_func_ff;
      bc_next    = (addr_next == 8'h00);
   end

   // Classification of each beat, next phase and jobs for the back.
   always_comb begin
      rx_crc_in     = rx_crc_ff;
      rx_count_in   = rx_count_ff;
      frame_addr_in = frame_addr_ff;
      frame_func_in = frame_func_ff;
      phase_in      = phase_ff;
      tx_started_in = tx_started_ff;
      broadcast_in  = broadcast_ff;
      q_push        = 1'b0;
      q_job         = '0;
      q_job.kind    = mrfc_pkg::JK_VERDICT;

      if (accept) begin
         case (req_chan.cmd)
            mrfc_pkg::CMD_RX_BYTE: begin
               // A frame byte abandons any pending reply.
               if (phase_ff != mrfc_pkg::PH_RECEIVING) begin
                  phase_in      = mrfc_pkg::PH_RECEIVING;
                  tx_started_in = 1'b0;
               end
               frame_addr_in = addr_next;
               frame_func_in = func_next;
               rx_crc_in     = crc_next;
               rx_count_in   = count_next;
               if (req_chan.last) begin
                  q_push     = 1'b1;
                  q_job.kind = mrfc_pkg::JK_VERDICT;
                  if (count_next < CountWidth'(mrfc_pkg::MIN_FRAME_BYTES)) begin
                     q_job.verdict = mrfc_pkg::VERDICT_TOO_SHORT;
                  end else if (crc_next != 16'h0000) begin
                     q_job.verdict = mrfc_pkg::VERDICT_CRC_BAD;
                  end else if (addr_next != device_address && !bc_next) begin
                     q_job.verdict = mrfc_pkg::VERDICT_NOT_ADDRESSED;
                  end else if (count_next < CountWidth'(mrfc_pkg::MIN_PDU_FRAME_BYTES)) begin
                     q_job.verdict = mrfc_pkg::VERDICT_PDU_SHORT;
                  end else begin
                     q_job.verdict   = mrfc_pkg::VERDICT_ACCEPTED;
                     q_job.func      = func_next;
                     q_job.broadcast = bc_next;
                     broadcast_in    = bc_next;
                     phase_in        = mrfc_pkg::PH_AWAITING;
                  end
                  rx_crc_in   = mrfc_pkg::CRC_INIT;
                  rx_count_in = '0;
               end
            end
            mrfc_pkg::CMD_OUTCOME: begin
               if (phase_ff == mrfc_pkg::PH_AWAITING) begin
                  if (broadcast_ff) begin
                     phase_in = mrfc_pkg::PH_RECEIVING;
                  end else if (req_chan.data_byte != 8'h00) begin
                     // Exception reply: the back builds all five bytes.
                     q_push      = 1'b1;
                     q_job.kind  = mrfc_pkg::JK_EXCEPTION;
                     q_job.func  = frame_func_ff;
                     q_job.data  = req_chan.data_byte;
                     q_job.first = 1'b1;
                     q_job.last  = 1'b1;
                     phase_in    = mrfc_pkg::PH_RECEIVING;
                  end else begin
                     phase_in      = mrfc_pkg::PH_RESPONDING;
                     tx_started_in = 1'b0;
                  end
               end
            end
            mrfc_pkg::CMD_PDU_BYTE: begin
               if (phase_ff == mrfc_pkg::PH_RESPONDING) begin
                  q_push        = 1'b1;
                  q_job.kind    = mrfc_pkg::JK_PDU;
                  q_job.data    = req_chan.data_byte;
                  q_job.first   = !tx_started_ff;
                  q_job.last    = req_chan.last;
                  tx_started_in = 1'b1;
                  if (req_chan.last) begin
                     phase_in      = mrfc_pkg::PH_RECEIVING;
                     tx_started_in = 1'b0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

endmodule

`default_nettype wire

### sv/mrfc_queue.sv
`default_nettype none

module mrfc_queue (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        push,
   input  wire mrfc_pkg::job_type     push_job,
   input  wire                        pop,
   output mrfc_pkg::queue_status_type status,
   output mrfc_pkg::job_type          head_job
);

   mrfc_pkg::job_type                  store_ff [mrfc_pkg::QUEUE_DEPTH];
   logic [mrfc_pkg::QUEUE_IDX_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [mrfc_pkg::QUEUE_IDX_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [mrfc_pkg::QUEUE_CNT_W-1:0]   count_ff, count_in;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == mrfc_pkg::QUEUE_IDX_W'(mrfc_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + mrfc_pkg::QUEUE_IDX_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == mrfc_pkg::QUEUE_IDX_W'(mrfc_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + mrfc_pkg::QUEUE_IDX_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + mrfc_pkg::QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - mrfc_pkg::QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Job storage.
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head_job     = store_ff[rd_ptr_ff];
   assign status.full  = (count_ff == mrfc_pkg::QUEUE_CNT_W'(mrfc_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

`default_nettype wire

### sv/mrfc_back.sv
`default_nettype none

module mrfc_back (
   input  wire                        clock,
   input  wire                        reset,
   input  wire [7:0]                  device_address,
   input  wire mrfc_pkg::queue_status_type q_status,
   input  wire mrfc_pkg::job_type     head_job,
   output logic                       q_pop,
   mrfc_rsp_if.source                 rsp_chan
);

   mrfc_pkg::step_type step_ff, step_in;
   logic               active_ff, active_in;
   logic [15:0]        crc_ff, crc_in;

   logic               valid_ff, valid_in;
   logic               kind_ff, kind_in;
   logic [2:0]         verdict_ff, verdict_in;
   logic [7:0]         func_ff, func_in;
   logic               bc_ff, bc_in;
   logic [7:0]         tx_byte_ff, tx_byte_in;
   logic               tx_last_ff, tx_last_in;

   logic               out_free;
   logic               emit;
   mrfc_pkg::step_type cur_step;

   // The output register takes a new beat when empty or being drained.
   assign out_free = !valid_ff || rsp_chan.ready;
   assign emit     = out_free && !q_status.empty;

   // Step of the head job: from the register once started, else its first step.
   always_comb begin
      if (active_ff) begin
         cur_step = step_ff;
      end else if (head_job.kind == mrfc_pkg::JK_EXCEPTION || head_job.first) begin
         cur_step = mrfc_pkg::ST_ADDR;
      end else begin
         cur_step = mrfc_pkg::ST_DATA;
      end
   end

   // Sequencer: one output beat per cycle from the head job while the output register is free and a job is queued.
   always_comb begin
      step_in    = step_ff;
      active_in  = active_ff;
      crc_in     = crc_ff;
      q_pop      = 1'b0;
      valid_in   = rsp_chan.ready ? 1'b0 : valid_ff;
      kind_in    = kind_ff;
      verdict_in = verdict_ff;
      func_in    = func_ff;
      bc_in      = bc_ff;
      tx_byte_in = tx_byte_ff;
      tx_last_in = tx_last_ff;

      if (emit) begin
         valid_in   = 1'b1;
         verdict_in = '0;
         func_in    = '0;
         bc_in      = 1'b0;
         tx_byte_in = '0;
         tx_last_in = 1'b0;
         if (head_job.kind == mrfc_pkg::JK_VERDICT) begin
            kind_in    = mrfc_pkg::KIND_VERDICT;
            verdict_in = head_job.verdict;
            func_in    = head_job.func;
            bc_in      = head_job.broadcast;
            q_pop      = 1'b1;
            active_in  = 1'b0;
         end else begin
            kind_in   = mrfc_pkg::KIND_TX_BYTE;
            active_in = 1'b1;
            case (cur_step)
               mrfc_pkg::ST_ADDR: begin
                  tx_byte_in = device_address;
                  crc_in     = mrfc_pkg::crc_byte(mrfc_pkg::CRC_INIT, device_address);
                  step_in    = (head_job.kind == mrfc_pkg::JK_EXCEPTION) ?
                               mrfc_pkg::ST_FUNC : mrfc_pkg::ST_DATA;
               end
               mrfc_pkg::ST_FUNC: begin
                  tx_byte_in = head_job.func | mrfc_pkg::EXC_FUNC_FLAG;
                  crc_in     = mrfc_pkg::crc_byte(crc_ff,
                                                  head_job.func | mrfc_pkg::EXC_FUNC_FLAG);
                  step_in    = mrfc_pkg::ST_DATA;
               end
               mrfc_pkg::ST_DATA: begin
                  tx_byte_in = head_job.data;
                  crc_in     = mrfc_pkg::crc_byte(crc_ff, head_job.data);
                  if (head_job.last) begin
                     step_in = mrfc_pkg::ST_CRC_LO;
                  end else begin
                     q_pop     = 1'b1;
                     active_in = 1'b0;
                  end
               end
               mrfc_pkg::ST_CRC_LO: begin
                  tx_byte_in = crc_ff[7:0];
                  step_in    = mrfc_pkg::ST_CRC_HI;
               end
               mrfc_pkg::ST_CRC_HI: begin
                  tx_byte_in = crc_ff[15:8];
                  tx_last_in = 1'b1;
                  q_pop      = 1'b1;
                  active_in  = 1'b0;
               end
               default: begin
                  q_pop     = 1'b1;
                  active_in = 1'b0;
               end
            endcase
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= mrfc_pkg::ST_ADDR;
         active_ff <= 1'b0;
         crc_ff    <= mrfc_pkg::CRC_INIT;
         valid_ff  <= 1'b0;
      end else begin
         step_ff   <= step_in;
         active_ff <= active_in;
         crc_ff    <= crc_in;
         valid_ff  <= valid_in;
      end
   end

   // Output payload registers.
   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      verdict_ff <= verdict_in;
      func_ff    <= func_in;
      bc_ff      <= bc_in;
      tx_byte_ff <= tx_byte_in;
      tx_last_ff <= tx_last_in;
   end

   assign rsp_chan.valid         = valid_ff;
   assign rsp_chan.kind          = kind_ff;
   assign rsp_chan.verdict       = verdict_ff;
   assign rsp_chan.function_code = func_ff;
   assign rsp_chan.is_broadcast  = bc_ff;
   assign rsp_chan.tx_byte       = tx_byte_ff;
   assign rsp_chan.tx_last       = tx_last_ff;

endmodule

`default_nettype wire

### sv/modbus_rtu_frame_check_and_reply_top.sv
`default_nettype none

// Channel   Direction  Handshake        Beat contents
// req_chan  in         valid/ready      cmd, data_byte, last
// rsp_chan  out        valid/ready      kind, verdict, function_code, is_broadcast,
//                                       tx_byte, tx_last
// csr_*     in         write enable     device_address (8 bits, reset 1)
//
// The front takes one request beat per cycle while the four-entry job queue has room.
// The back emits one response beat per cycle from a registered output while the receiver is
// ready and a job is queued: one beat per received frame, one per middle PDU byte, two for the
// first PDU byte, three for the last, four for a one-byte PDU, five for an exception reply;
// the output register sets that pace. Synchronous active-high reset; no clearing pass.
// Response stalls fill the queue and then hold off requests.

module modbus_rtu_frame_check_and_reply_top #(
   parameter int MAX_FRAME_BYTES = mrfc_pkg::MAX_FRAME_BYTES_DEFAULT
) (
   input  wire        clock,
   input  wire        reset,
   mrfc_req_if.sink   req_chan,
   mrfc_rsp_if.source rsp_chan,
   input  wire        csr_write_enable,
   input  wire [7:0]  csr_write_data
);

   logic [7:0]                 device_address_ff;
   logic                       q_push;
   logic                       q_pop;
   mrfc_pkg::job_type          q_job;
   mrfc_pkg::job_type          head_job;
   mrfc_pkg::queue_status_type q_status;

   // Own slave address register.
   always_ff @(posedge clock) begin
      if (reset) begin
         device_address_ff <= mrfc_pkg::DEVICE_ADDRESS_RESET;
      end else if (csr_write_enable) begin
         device_address_ff <= csr_write_data;
      end
   end

   mrfc_front #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .device_address (device_address_ff),
      .q_status       (q_status),
      .q_push         (q_push),
      .q_job          (q_job)
   );

   mrfc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_job),
      .pop      (q_pop),
      .status   (q_status),
      .head_job (head_job)
   );

   mrfc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .device_address (device_address_ff),
      .q_status       (q_status),
      .head_job       (head_job),
      .q_pop          (q_pop),
      .rsp_chan       (rsp_chan)
   );

endmodule

`default_nettype wire

### tb/sv/modbus_rtu_frame_check_and_reply_top_tb.sv
module modbus_rtu_frame_check_and_reply_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD    = 10;
   localparam int RESET_CYCLES  = 8;
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_CYCLES   = 80;
   localparam int STALL_LIMIT   = 1000;
   // Small byte-count limit so that saturation shows up in short frames.
   localparam int FRAME_LIMIT   = 16;

   // Command code that the block has no use for.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // One response beat as the checker sees it.
   typedef struct packed {
      logic       kind;
      logic [2:0] verdict;
      logic [7:0] function_code;
      logic       is_broadcast;
      logic [7:0] tx_byte;
      logic       tx_last;
   } rsp_beat_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_write_enable;
   logic [7:0] csr_write_data;

   mrfc_req_if req_if ();
   mrfc_rsp_if rsp_if ();

   modbus_rtu_frame_check_and_reply_top #(
      .MAX_FRAME_BYTES (FRAME_LIMIT)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Response beats still owed by the block, oldest first.
   rsp_beat_type awaited_rsp_beats[$];
   rsp_beat_type oldest_beat;
   int         fail_count = 0;
   int         items_sent = 0;

   // Idling controls for the sender and the receiver.
   bit         sender_gaps     = 1'b0;
   bit         receiver_stalls = 1'b0;
   bit         hold_response   = 1'b0;
   bit         req_up          = 1'b0;

   // Frame under construction for the receive side.
   logic [7:0] frame_bytes[$];

   // Link state as the block should hold it.
   logic [7:0] own_address;
   logic [15:0] rx_crc_acc;
   int unsigned rx_len;
   logic [7:0] rx_addr_byte;
   logic [7:0] rx_func_byte;
   mrfc_pkg::phase_type link_phase;
   logic [15:0] reply_crc;
   logic       reply_started;
   logic       bcast_pending;

   // CRC-16/MODBUS over one byte, shifting out the low bit each round.
   function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] data);
      logic [15:0] r;
      r = crc ^ {8'h00, data};
      repeat (8) r = {1'b0, r[15:1]} ^ (r[0] ? mrfc_pkg::CRC_POLY : 16'h0000);
      return r;
   endfunction

   function automatic void push_verdict(logic [2:0] code, logic [7:0] func, logic bcast);
      rsp_beat_type beat;
      beat = '0;
      beat.kind = mrfc_pkg::KIND_VERDICT;
      beat.verdict = code;
      beat.function_code = func;
      beat.is_broadcast = bcast;
      awaited_rsp_beats.push_back(beat);
   endfunction

   function automatic void push_tx(logic [7:0] data, logic fin);
      rsp_beat_type beat;
      beat = '0;
      beat.kind = mrfc_pkg::KIND_TX_BYTE;
      beat.tx_byte = data;
      beat.tx_last = fin;
      awaited_rsp_beats.push_back(beat);
   endfunction

   function automatic void clear_link_state();
      own_address = mrfc_pkg::DEVICE_ADDRESS_RESET;
      rx_crc_acc = mrfc_pkg::CRC_INIT;
      rx_len = 0;
      rx_addr_byte = 8'h00;
      rx_func_byte = 8'h00;
      link_phase = mrfc_pkg::PH_RECEIVING;
      reply_crc = mrfc_pkg::CRC_INIT;
      reply_started = 1'b0;
      bcast_pending = 1'b0;
   endfunction

   // Works out the response beats that one accepted request beat causes.
   function automatic void forecast_rsp_beats(logic [1:0] cmd, logic [7:0] data, logic fin);
      logic        bcast;
      logic [7:0]  exc_func;
      logic [15:0] c;
      case (cmd)
         mrfc_pkg::CMD_RX_BYTE: begin
            // A frame byte always drops any reply in progress.
            if (link_phase != mrfc_pkg::PH_RECEIVING) begin
               link_phase = mrfc_pkg::PH_RECEIVING;
               reply_started = 1'b0;
               reply_crc = mrfc_pkg::CRC_INIT;
            end
            if (rx_len == 0) begin
               rx_addr_byte = data;
            end else if (rx_len == 1) begin
               rx_func_byte = data;
            end
            rx_crc_acc = crc16_step(rx_crc_acc, data);
            if (rx_len < FRAME_LIMIT) rx_len++;
            if (fin) begin
               bcast = (rx_addr_byte == 8'h00);
               if (rx_len < mrfc_pkg::MIN_FRAME_BYTES) begin
                  push_verdict(mrfc_pkg::VERDICT_TOO_SHORT, 8'h00, 1'b0);
               end else if (rx_crc_acc != 16'h0000) begin
                  push_verdict(mrfc_pkg::VERDICT_CRC_BAD, 8'h00, 1'b0);
               end else if (rx_addr_byte != own_address && !bcast) begin
                  push_verdict(mrfc_pkg::VERDICT_NOT_ADDRESSED, 8'h00, 1'b0);
               end else if (rx_len < mrfc_pkg::MIN_PDU_FRAME_BYTES) begin
                  push_verdict(mrfc_pkg::VERDICT_PDU_SHORT, 8'h00, 1'b0);
               end else begin
                  push_verdict(mrfc_pkg::VERDICT_ACCEPTED, rx_func_byte, bcast);
                  bcast_pending = bcast;
                  link_phase = mrfc_pkg::PH_AWAITING;
               end
               rx_crc_acc = mrfc_pkg::CRC_INIT;
               rx_len = 0;
            end
         end
         mrfc_pkg::CMD_OUTCOME: begin
            if (link_phase == mrfc_pkg::PH_AWAITING) begin
               if (bcast_pending) begin
                  link_phase = mrfc_pkg::PH_RECEIVING;
               end else if (data != 8'h00) begin
                  // Exception reply: address, flagged function, code, CRC.
                  exc_func = rx_func_byte | mrfc_pkg::EXC_FUNC_FLAG;
                  c = crc16_step(crc16_step(crc16_step(mrfc_pkg::CRC_INIT, own_address),
                                            exc_func), data);
                  push_tx(own_address, 1'b0);
                  push_tx(exc_func, 1'b0);
                  push_tx(data, 1'b0);
                  push_tx(c[7:0], 1'b0);
                  push_tx(c[15:8], 1'b1);
                  link_phase = mrfc_pkg::PH_RECEIVING;
               end else begin
                  link_phase = mrfc_pkg::PH_RESPONDING;
                  reply_started = 1'b0;
                  reply_crc = mrfc_pkg::CRC_INIT;
               end
            end
         end
         mrfc_pkg::CMD_PDU_BYTE: begin
            if (link_phase == mrfc_pkg::PH_RESPONDING) begin
               if (!reply_started) begin
                  reply_crc = crc16_step(mrfc_pkg::CRC_INIT, own_address);
                  push_tx(own_address, 1'b0);
                  reply_started = 1'b1;
               end
               reply_crc = crc16_step(reply_crc, data);
               push_tx(data, 1'b0);
               if (fin) begin
                  push_tx(reply_crc[7:0], 1'b0);
                  push_tx(reply_crc[15:8], 1'b1);
                  link_phase = mrfc_pkg::PH_RECEIVING;
                  reply_started = 1'b0;
                  reply_crc = mrfc_pkg::CRC_INIT;
               end
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, got %0h", field, want, got);
         fail_count++;
      end
   endfunction

   // Offers one request beat, with an optional gap first, and waits for it to be taken.
   // Valid stays high afterwards so back-to-back beats leave no gap.
   task automatic send_beat(input logic [1:0] cmd, input logic [7:0] data, input logic fin);
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         if (req_up) begin
            req_if.valid <= 1'b0;
            req_up = 1'b0;
         end
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.cmd       <= cmd;
      req_if.data_byte <= data;
      req_if.last      <= fin;
      req_up = 1'b1;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      forecast_rsp_beats(cmd, data, fin);
      items_sent++;
   endtask

   task automatic release_request();
      if (req_up) begin
         req_if.valid <= 1'b0;
         req_up = 1'b0;
      end
   endtask

   // Waits until every owed beat has come, then lets the queue settle.
   task automatic drain_results();
      release_request();
      while (awaited_rsp_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_address(input logic [7:0] addr);
      csr_write_enable <= 1'b1;
      csr_write_data   <= addr;
      own_address = addr;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic build_frame(input logic [7:0] addr, input logic [7:0] func, input int plen);
      frame_bytes.delete();
      frame_bytes.push_back(addr);
      frame_bytes.push_back(func);
      repeat (plen) frame_bytes.push_back(8'($urandom));
   endtask

   // Sends the frame under construction, optionally closed by its CRC.
   task automatic send_frame(input bit add_crc, input bit corrupt);
      logic [15:0] c;
      c = mrfc_pkg::CRC_INIT;
      if (add_crc) begin
         foreach (frame_bytes[i]) c = crc16_step(c, frame_bytes[i]);
         if (corrupt) c = c ^ (16'h0001 << $urandom_range(0, 15));
         frame_bytes.push_back(c[7:0]);
         frame_bytes.push_back(c[15:8]);
      end
      for (int i = 0; i < frame_bytes.size(); i++) begin
         send_beat(mrfc_pkg::CMD_RX_BYTE, frame_bytes[i], i == frame_bytes.size() - 1);
      end
   endtask

   task automatic send_pdu(input int count);
      for (int i = 0; i < count; i++) begin
         send_beat(mrfc_pkg::CMD_PDU_BYTE, 8'($urandom), i == count - 1);
      end
   endtask

   // Brings the link back to receiving, whatever reply is pending.
   task automatic complete_reply(input logic [7:0] code);
      if (link_phase == mrfc_pkg::PH_AWAITING) send_beat(mrfc_pkg::CMD_OUTCOME, code, 1'b0);
      if (link_phase == mrfc_pkg::PH_RESPONDING) send_pdu($urandom_range(1, 4));
   endtask

   task automatic test_frame_verdicts();
      // Single byte with every bit low.
      frame_bytes.delete();
      frame_bytes.push_back(8'h00);
      send_frame(1'b0, 1'b0);
      build_frame(own_address, 8'hFF, 1);
      send_frame(1'b0, 1'b0);
      build_frame(own_address, 8'h03, 2);
      send_frame(1'b1, 1'b1);
      build_frame(8'hFF, 8'h03, 0);
      send_frame(1'b1, 1'b0);
      build_frame(own_address, 8'h04, 3);
      send_frame(1'b1, 1'b0);
   endtask

   task automatic test_exception_reply();
      // Stray beats in the receiving phase do nothing.
      send_beat(mrfc_pkg::CMD_OUTCOME, 8'h01, 1'b1);
      send_beat(mrfc_pkg::CMD_PDU_BYTE, 8'hAA, 1'b1);
      send_beat(CMD_UNUSED, 8'hFF, 1'b1);
      build_frame(own_address, 8'h7F, 4);
      send_frame(1'b1, 1'b0);
      send_beat(mrfc_pkg::CMD_OUTCOME, 8'hFF, 1'b0);
   endtask

   task automatic test_pdu_reply();
      build_frame(own_address, 8'h03, 4);
      send_frame(1'b1, 1'b0);
      send_beat(mrfc_pkg::CMD_OUTCOME, 8'h00, 1'b0);
      // An outcome while responding is ignored.
      send_beat(mrfc_pkg::CMD_OUTCOME, 8'h02, 1'b0);
      send_beat(mrfc_pkg::CMD_PDU_BYTE, 8'h00, 1'b0);
      send_beat(mrfc_pkg::CMD_PDU_BYTE, 8'hFF, 1'b1);
   endtask

   task automatic test_broadcast();
      build_frame(8'h00, 8'h06, 4);
      send_frame(1'b1, 1'b0);
      send_beat(mrfc_pkg::CMD_OUTCOME, 8'h05, 1'b0);
      send_beat(mrfc_pkg::CMD_PDU_BYTE, 8'h12, 1'b1);
      build_frame(8'h00, 8'h10, 5);
      send_frame(1'b1, 1'b0);
      send_beat(mrfc_pkg::CMD_OUTCOME, 8'h00, 1'b0);
      send_beat(mrfc_pkg::CMD_PDU_BYTE, 8'h34, 1'b1);
   endtask

   task automatic test_reply_abandon();
      // A frame byte in the middle of a reply cuts it off.
      build_frame(own_address, 8'h03, 4);
      send_frame(1'b1, 1'b0);
      send_beat(mrfc_pkg::CMD_OUTCOME, 8'h00, 1'b0);
      send_beat(mrfc_pkg::CMD_PDU_BYTE, 8'h11, 1'b0);
      send_beat(mrfc_pkg::CMD_RX_BYTE, 8'h55, 1'b1);
      // The same while the outcome is still pending.
      build_frame(own_address, 8'h04, 4);
      send_frame(1'b1, 1'b0);
      send_beat(mrfc_pkg::CMD_RX_BYTE, 8'hA5, 1'b1);
   endtask

   task automatic test_long_frame();
      // Byte count saturates at the limit in a frame well past it, but the CRC still covers every byte.
      build_frame(own_address, 8'h10, 30);
      send_frame(1'b1, 1'b0);
      send_beat(mrfc_pkg::CMD_OUTCOME, 8'h04, 1'b0);
   endtask

   task automatic test_address_register();
      logic [7:0] addr_list[3];
      addr_list = '{8'h00, 8'hFF, 8'($urandom)};
      foreach (addr_list[k]) begin
         drain_results();
         write_address(addr_list[k]);
         build_frame(own_address, 8'h01, 4);
         send_frame(1'b1, 1'b0);
         complete_reply(8'h0B);
         build_frame(own_address ^ 8'h80, 8'h03, 4);
         send_frame(1'b1, 1'b0);
         complete_reply(8'h01);
      end
   endtask

   task automatic test_response_backpressure();
      // The receiver holds off while short frames keep coming, so the queue fills.
      sender_gaps = 1'b0;
      receiver_stalls = 1'b0;
      hold_response = 1'b1;
      repeat (16) begin
         frame_bytes.delete();
         frame_bytes.push_back(8'($urandom));
         send_frame(1'b0, 1'b0);
      end
      build_frame(own_address, 8'h05, 4);
      send_frame(1'b1, 1'b0);
      send_beat(mrfc_pkg::CMD_OUTCOME, 8'h03, 1'b0);
   endtask

   // One random exchange: mostly well-formed frames and replies, some noise.
   task automatic random_exchange();
      int         pick;
      int         plen;
      int         npdu;
      int         crc_mode;
      logic [7:0] dest;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         send_beat(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
      end else begin
         pick = $urandom_range(0, 9);
         dest = (pick < 7) ? own_address : (pick == 7) ? 8'h00 : 8'($urandom);
         plen = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 10);
         build_frame(dest, 8'($urandom), plen);
         crc_mode = $urandom_range(0, 19);
         send_frame(crc_mode != 0, crc_mode == 1);
         if (link_phase == mrfc_pkg::PH_AWAITING && $urandom_range(0, 9) != 0) begin
            send_beat(mrfc_pkg::CMD_OUTCOME,
                      ($urandom_range(0, 2) == 0) ? 8'($urandom_range(1, 255)) : 8'h00,
                      1'($urandom));
         end
         if (link_phase == mrfc_pkg::PH_RESPONDING) begin
            npdu = $urandom_range(1, 6);
            for (int i = 0; i < npdu; i++) begin
               if ($urandom_range(0, 19) == 0) begin
                  send_beat(mrfc_pkg::CMD_OUTCOME, 8'($urandom), 1'($urandom));
               end
               send_beat(mrfc_pkg::CMD_PDU_BYTE, 8'($urandom),
                         (i == npdu - 1) && ($urandom_range(0, 9) != 0));
            end
         end
      end
   endtask

   task automatic test_random_traffic();
      int target;
      for (int round = 0; round < 4; round++) begin
         drain_results();
         write_address(8'($urandom));
         // The last round runs with no idling on either side.
         sender_gaps = (round < 2);
         receiver_stalls = (round == 0 || round == 2);
         target = items_sent + 10;
         while (items_sent < target) random_exchange();
      end
   endtask

   // Receiver: random stall bursts, one long hold-off on request, or always ready.
   initial begin : response_sink
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_response) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_response = 1'b0;
            rsp_if.ready <= 1'b1;
         end else if (receiver_stalls && $urandom_range(0, 4) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Each response beat is compared with the oldest owed beat.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (awaited_rsp_beats.size() == 0) begin
            $error("response beat with none owed: kind %0d tx_byte %0h",
                   rsp_if.kind, rsp_if.tx_byte);
            fail_count++;
         end else begin
            oldest_beat = awaited_rsp_beats.pop_front();
            check_field("kind", 8'(oldest_beat.kind), 8'(rsp_if.kind));
            check_field("verdict", 8'(oldest_beat.verdict), 8'(rsp_if.verdict));
            check_field("function_code", oldest_beat.function_code, rsp_if.function_code);
            check_field("is_broadcast", 8'(oldest_beat.is_broadcast), 8'(rsp_if.is_broadcast));
            check_field("tx_byte", oldest_beat.tx_byte, rsp_if.tx_byte);
            check_field("tx_last", 8'(oldest_beat.tx_last), 8'(rsp_if.tx_last));
         end
      end
   end

   // Ends the run if no beat moves on either channel for too long.
   initial begin : watchdog
      int stalled;
      stalled = 0;
      while (stalled < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            stalled = 0;
         end else begin
            stalled++;
         end
      end
      $error("no beat accepted for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.cmd       <= mrfc_pkg::CMD_RX_BYTE;
      req_if.data_byte <= 8'h00;
      req_if.last      <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= 8'h00;
      clear_link_state();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      sender_gaps = 1'b1;
      receiver_stalls = 1'b1;
      test_frame_verdicts();
      test_exception_reply();
      test_pdu_reply();
      test_broadcast();
      test_reply_abandon();
      test_long_frame();
      test_address_register();
      test_response_backpressure();
      test_random_traffic();

      drain_results();
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

### modbus_rtu_frame_check_and_reply_top.f
sv/mrfc_pkg.sv
sv/mrfc_if.sv
sv/mrfc_front.sv
sv/mrfc_queue.sv
sv/mrfc_back.sv
sv/modbus_rtu_frame_check_and_reply_top.sv
tb/sv/modbus_rtu_frame_check_and_reply_top_tb.sv
